// ----- sv/rfpcb_pkg.sv -----
// ----------------------------------------------------------------------------
// rfpcb_pkg : shared types, constants and functions of the payload builder
// Holds the queue word layout, the whitening and CRC byte steps and the
// table of outer whitening start states, one per seed value.
// ----------------------------------------------------------------------------
package rfpcb_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [5:0]  SeedReset  = 6'd37;
  localparam logic [15:0] CrcInit    = 16'hFFFF;
  localparam logic [15:0] CrcPoly    = 16'h1021;
  localparam logic [6:0]  InnerInit  = 7'h3F | 7'h40;
  localparam logic [6:0]  PosMax     = 7'h7F;
  localparam int unsigned LeadSteps  = 120;
  localparam int unsigned NumSeeds   = 64;

  // Word passed from the front to the back through the queue.
  typedef struct packed {
    logic [7:0] crc_in;  // byte as it enters the CRC
    logic [7:0] body;    // byte as it enters the whitening
    logic       first;   // opens a packet
    logic       last;    // closes a packet
  } q_word_t;

  // Result of one whitening byte step.
  typedef struct packed {
    logic [6:0] state;
    logic [7:0] data;
  } lfsr_res_t;

  typedef logic [6:0] seed_tab_t [NumSeeds];

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7 - i] = v[i];
    end
    return r;
  endfunction

  function automatic logic [15:0] rev16(input logic [15:0] v);
    logic [15:0] r;
    for (int i = 0; i < 16; i++) begin
      r[15 - i] = v[i];
    end
    return r;
  endfunction

  // One shift of the 7-cell register; cell 6 feeds back into cells 0 and 4.
  function automatic logic [6:0] lfsr_next(input logic [6:0] v);
    return {v[5], v[4], v[3] ^ v[6], v[2], v[1], v[0], v[6]};
  endfunction

  // Whiten one byte LSB first, eight shifts.
  function automatic lfsr_res_t lfsr_byte(input logic [6:0] s, input logic [7:0] b);
    lfsr_res_t r;
    logic [6:0] st;
    st = s;
    for (int i = 0; i < 8; i++) begin
      r.data[i] = st[6] ^ b[i];
      st        = lfsr_next(st);
    end
    r.state = st;
    return r;
  endfunction

  // CCITT CRC over one byte, MSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // Outer start state for every seed: cell 0 set, cells 1..6 from seed bits
  // 5..0, then run past the lead-in. Evaluated at elaboration only.
  function automatic seed_tab_t build_seed_tab();
    seed_tab_t  t;
    logic [6:0] s;
    for (int k = 0; k < NumSeeds; k++) begin
      s = 7'h01;
      for (int i = 0; i < 6; i++) begin
        s[i + 1] = k[5 - i];
      end
      for (int j = 0; j < LeadSteps; j++) begin
        s = lfsr_next(s);
      end
      t[k] = s;
    end
    return t;
  endfunction

  localparam seed_tab_t SeedTab = build_seed_tab();

  // Header bytes, already bit-reversed.
  localparam logic [7:0] HdrRev0 = rev8(8'h71);
  localparam logic [7:0] HdrRev1 = rev8(8'h0F);
  localparam logic [7:0] HdrRev2 = rev8(8'h55);

endpackage

// ----- sv/rf_payload_crc_whitening_builder.sv -----
// ----------------------------------------------------------------------------
// rf_payload_crc_whitening_builder : radio payload builder, CRC-16 + whitening
// Turns a stream of address and data bytes into a fixed-length payload with
// header, whitened body, whitened CRC and padding.
// ----------------------------------------------------------------------------
//
//   group     dir  tdata          tuser        tlast
//   s_axis    in   in_byte[7:0]   is_address   last
//   m_axis    out  out_byte[7:0]  -            last_out
//   cfg       in   whiten_seed on cfg_wdata_i[5:0], written when cfg_we_i
//
// Cycles: one output word per cycle while words are queued and m_axis_tready
//   is high. The first word of a packet is preceded by three header bytes, the
//   last word is followed by two CRC bytes and padding up to PAYLOAD_BYTES.
//   The byte sequencer in the back, emitting one byte a cycle, sets this rate.
// Reset: no clearing pass; the block takes words straight after reset.
// Stalls: a four-word queue lets input words be taken while the sequencer
//   waits on m_axis_tready or works through header, CRC or padding.
// ----------------------------------------------------------------------------
module rf_payload_crc_whitening_builder #(
  parameter int unsigned PAYLOAD_BYTES = 24  // payload length in bytes, 8..64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration: whiten_seed
  input  logic       cfg_we_i,
  input  logic [5:0] cfg_wdata_i,
  // input stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tuser,   // [0] is_address
  input  logic       s_axis_tlast,
  // output stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast
);

  logic [5:0]         seed_q, seed_d;
  logic               push, pop, q_full, head_valid;
  rfpcb_pkg::q_word_t push_word, head_word;

  // Hold the seed; it is sampled by the back only at a packet start.
  always_comb begin
    seed_d = cfg_we_i ? cfg_wdata_i : seed_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= rfpcb_pkg::SeedReset;
    end else begin
      seed_q <= seed_d;
    end
  end

  // Front: accept words, flag packet starts, prepare reversed forms.
  rfpcb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .q_full_i      (q_full),
    .push_o        (push),
    .word_o        (push_word)
  );

  // Queue: let front and back stall independently.
  rfpcb_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .word_i       (push_word),
    .pop_i        (pop),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head_word)
  );

  // Back: sequence header, body, CRC and padding into the output register.
  rfpcb_back #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .seed_i        (seed_q),
    .head_valid_i  (head_valid),
    .head_i        (head_word),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ----- sv/rfpcb_front.sv -----
// ----------------------------------------------------------------------------
// rfpcb_front : input acceptance and classification
// Marks packet starts and prepares the CRC and whitening forms of each byte.
// ----------------------------------------------------------------------------
module rfpcb_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,
  input  logic              s_axis_tuser,
  input  logic              s_axis_tlast,
  input  logic              q_full_i,
  output logic              push_o,
  output rfpcb_pkg::q_word_t word_o
);

  logic in_pkt_q, in_pkt_d;
  logic [7:0] rev_byte;

  assign s_axis_tready = !q_full_i;
  assign push_o        = s_axis_tvalid && s_axis_tready;
  assign rev_byte      = rfpcb_pkg::rev8(s_axis_tdata);

  // Address bytes go out reversed, data bytes enter the CRC reversed.
  always_comb begin
    word_o.crc_in = s_axis_tuser ? s_axis_tdata : rev_byte;
    word_o.body   = s_axis_tuser ? rev_byte : s_axis_tdata;
    word_o.first  = !in_pkt_q;
    word_o.last   = s_axis_tlast;
  end

  always_comb begin
    in_pkt_d = in_pkt_q;
    if (push_o) begin
      in_pkt_d = !s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_pkt_q <= 1'b0;
    end else begin
      in_pkt_q <= in_pkt_d;
    end
  end

endmodule

// ----- sv/rfpcb_queue.sv -----
// ----------------------------------------------------------------------------
// rfpcb_queue : short word queue between front and back
// Decouples acceptance of input words from the byte sequencer.
// ----------------------------------------------------------------------------
module rfpcb_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  rfpcb_pkg::q_word_t word_i,
  input  logic               pop_i,
  output logic               full_o,
  output logic               head_valid_o,
  output rfpcb_pkg::q_word_t head_o
);

  rfpcb_pkg::q_word_t mem_q [rfpcb_pkg::QDepth];
  logic [rfpcb_pkg::QPtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [rfpcb_pkg::QCntW-1:0] cnt_q, cnt_d;

  assign full_o       = (cnt_q == rfpcb_pkg::QCntW'(rfpcb_pkg::QDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? wptr_q + 1'b1 : wptr_q;
    rptr_d = pop_i  ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= word_i;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0) else $error("queue popped while empty");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue pushed while full");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= rfpcb_pkg::QCntW'(rfpcb_pkg::QDepth)) else $error("queue count overflow");

endmodule

// ----- sv/rfpcb_back.sv -----
// ----------------------------------------------------------------------------
// rfpcb_back : byte sequencer with CRC, whitening and output register
// Emits header, body, CRC and padding bytes, one per cycle unless m_axis_tready or an empty queue stalls it.
// ----------------------------------------------------------------------------
module rfpcb_back #(
  parameter int unsigned PAYLOAD_BYTES = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [5:0]         seed_i,
  input  logic               head_valid_i,
  input  rfpcb_pkg::q_word_t head_i,
  output logic               pop_o,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [7:0]         m_axis_tdata,
  output logic               m_axis_tlast
);

  typedef enum logic [2:0] {
    ST_BODY, ST_HDR1, ST_HDR2, ST_CRC0, ST_CRC1, ST_PAD
  } state_e;

  state_e      state_q, state_d;
  logic        hdr_done_q, hdr_done_d;
  logic [15:0] crc_q, crc_d;
  logic [6:0]  inner_q, inner_d, outer_q, outer_d, pos_q, pos_d;
  logic        out_valid_q, out_valid_d, out_last_q, out_last_d;
  logic [7:0]  out_byte_q, out_byte_d;

  logic        can_load, emit, emit_last, done;
  logic [7:0]  wh_src, hdr_src;
  logic [6:0]  hdr_outer, pos_inc;
  logic [15:0] crc_fin;
  rfpcb_pkg::lfsr_res_t w_in, w_out, hdr_w;

  assign can_load = !out_valid_q || m_axis_tready;
  assign crc_fin  = ~rfpcb_pkg::rev16(crc_q);
  assign pos_inc  = (pos_q == rfpcb_pkg::PosMax) ? pos_q : pos_q + 7'd1;
  assign done     = (pos_inc >= 7'(PAYLOAD_BYTES));

  always_comb begin
    case (state_q)
      ST_CRC0: wh_src = crc_fin[7:0];
      ST_CRC1: wh_src = crc_fin[15:8];
      default: wh_src = head_i.body;
    endcase
    case (state_q)
      ST_HDR1: hdr_src = rfpcb_pkg::HdrRev1;
      ST_HDR2: hdr_src = rfpcb_pkg::HdrRev2;
      default: hdr_src = rfpcb_pkg::HdrRev0;
    endcase
    hdr_outer = (state_q == ST_BODY) ? rfpcb_pkg::SeedTab[seed_i] : outer_q;
  end

  // Inner then outer whitening of body and CRC bytes; header uses outer only.
  assign w_in  = rfpcb_pkg::lfsr_byte(inner_q, wh_src);
  assign w_out = rfpcb_pkg::lfsr_byte(outer_q, w_in.data);
  assign hdr_w = rfpcb_pkg::lfsr_byte(hdr_outer, hdr_src);

  always_comb begin
    state_d    = state_q;
    hdr_done_d = hdr_done_q;
    crc_d      = crc_q;
    inner_d    = inner_q;
    outer_d    = outer_q;
    pos_d      = pos_q;
    emit       = 1'b0;
    emit_last  = 1'b0;
    out_byte_d = out_byte_q;
    pop_o      = 1'b0;
    if (can_load) begin
      case (state_q)
        ST_BODY: begin
          if (head_valid_i) begin
            emit = 1'b1;
            if (head_i.first && !hdr_done_q) begin
              // Reload per-packet state and send the first header byte.
              out_byte_d = hdr_w.data;
              outer_d    = hdr_w.state;
              crc_d      = rfpcb_pkg::CrcInit;
              inner_d    = rfpcb_pkg::InnerInit;
              pos_d      = 7'd1;
              state_d    = ST_HDR1;
            end else begin
              out_byte_d = w_out.data;
              inner_d    = w_in.state;
              outer_d    = w_out.state;
              crc_d      = rfpcb_pkg::crc_byte(crc_q, head_i.crc_in);
              pos_d      = pos_inc;
              pop_o      = 1'b1;
              hdr_done_d = 1'b0;
              if (head_i.last) begin
                state_d = ST_CRC0;
              end
            end
          end
        end
        ST_HDR1, ST_HDR2: begin
          emit       = 1'b1;
          out_byte_d = hdr_w.data;
          outer_d    = hdr_w.state;
          pos_d      = pos_inc;
          if (state_q == ST_HDR2) begin
            hdr_done_d = 1'b1;
            state_d    = ST_BODY;
          end else begin
            state_d    = ST_HDR2;
          end
        end
        ST_CRC0, ST_CRC1: begin
          emit       = 1'b1;
          out_byte_d = w_out.data;
          inner_d    = w_in.state;
          outer_d    = w_out.state;
          pos_d      = pos_inc;
          if (state_q == ST_CRC0) begin
            state_d = ST_CRC1;
          end else begin
            emit_last = done;
            state_d   = done ? ST_BODY : ST_PAD;
          end
        end
        ST_PAD: begin
          emit       = 1'b1;
          out_byte_d = {1'b0, pos_q} + 8'd1;
          pos_d      = pos_inc;
          emit_last  = done;
          if (done) begin
            state_d = ST_BODY;
          end
        end
        default: begin
          state_d = ST_BODY;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_last_d  = out_last_q;
    if (can_load) begin
      out_valid_d = emit;
    end
    if (emit) begin
      out_last_d = emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_BODY;
      hdr_done_q  <= 1'b0;
      crc_q       <= rfpcb_pkg::CrcInit;
      inner_q     <= rfpcb_pkg::InnerInit;
      outer_q     <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_byte_q  <= '0;
    end else begin
      state_q     <= state_d;
      hdr_done_q  <= hdr_done_d;
      crc_q       <= crc_d;
      inner_q     <= inner_d;
      outer_q     <= outer_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
      out_last_q  <= out_last_d;
      out_byte_q  <= out_byte_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;

  a_pop_in_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> state_q == ST_BODY && head_valid_i) else $error("pop outside body state");
  a_last_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_last |-> state_q == ST_CRC1 || state_q == ST_PAD) else $error("early last");
  a_pad_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PAD |-> pos_q < 7'(PAYLOAD_BYTES)) else $error("padding past payload");

endmodule

// ----- dv/rf_payload_crc_whitening_builder_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rf_payload_crc_whitening_builder_checker : payload predictor and scoreboard
// Watches the seed register port and both streams. For every input word taken
// it builds the payload bytes that word releases. It then compares each output
// word, in order, against the oldest byte still owed.
// ----------------------------------------------------------------------------
module rf_payload_crc_whitening_builder_checker #(
  parameter int unsigned PAYLOAD_BYTES = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tuser,   // [0] is_address
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  input  logic        m_axis_tlast,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);

  localparam logic [5:0]  ResetSeed  = 6'd37;
  localparam logic [15:0] CrcStart   = 16'hFFFF;
  localparam logic [15:0] CrcTaps    = 16'h1021;
  localparam logic [6:0]  InnerStart = 7'h7F;
  localparam int unsigned LeadIn     = 120;
  localparam int unsigned PosCeiling = 127;
  localparam logic [7:0]  SyncByte0  = 8'h71;
  localparam logic [7:0]  SyncByte1  = 8'h0F;
  localparam logic [7:0]  SyncByte2  = 8'h55;
  localparam int unsigned MaxReports = 200;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } payload_byte_t;

  logic [5:0]    seed_q;
  logic [15:0]   crc_acc;
  logic [6:0]    inner_st;
  logic [6:0]    outer_st;
  int unsigned   out_pos;
  bit            pkt_open;
  payload_byte_t payload_owed[$];
  int unsigned   fails;
  int unsigned   checked;

  function automatic logic [7:0] mirror8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[i] = v[7 - i];
    return r;
  endfunction

  function automatic logic [15:0] mirror16(input logic [15:0] v);
    logic [15:0] r;
    for (int i = 0; i < 16; i++) r[i] = v[15 - i];
    return r;
  endfunction

  // Cell 6 shifts out and feeds back into cell 0 and the input of cell 4.
  function automatic logic [6:0] shift7(input logic [6:0] v);
    logic fb;
    fb = v[6];
    return {v[5:4], v[3] ^ fb, v[2:0], fb};
  endfunction

  function automatic logic [6:0] lead_in_state(input logic [5:0] seed);
    logic [6:0] s;
    s[0] = 1'b1;
    for (int i = 0; i < 6; i++) s[i + 1] = seed[5 - i];
    for (int i = 0; i < LeadIn; i++) s = shift7(s);
    return s;
  endfunction

  function automatic logic [7:0] outer_mask(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i]     = outer_st[6] ^ b[i];
      outer_st = shift7(outer_st);
    end
    return r;
  endfunction

  // Inner register first, then the outer one, both LSB first.
  function automatic logic [7:0] whiten(input logic [7:0] b);
    logic [7:0] x;
    for (int i = 0; i < 8; i++) begin
      x[i]     = inner_st[6] ^ b[i];
      inner_st = shift7(inner_st);
    end
    return outer_mask(x);
  endfunction

  function automatic void owe_byte(input logic [7:0] data, input logic last);
    payload_owed.push_back({data, last});
    if (out_pos < PosCeiling) out_pos++;
  endfunction

  always @(posedge clk_i) begin : scoreboard
    payload_byte_t want;
    logic [7:0]    crc_in;
    logic [15:0]   crc_tail;
    if (!rst_ni) begin
      seed_q   = ResetSeed;
      crc_acc  = CrcStart;
      inner_st = InnerStart;
      outer_st = lead_in_state(ResetSeed);
      out_pos  = 0;
      pkt_open = 1'b0;
      payload_owed.delete();
    end else begin
      // Retire first: a byte caused by a word taken now cannot leave at this edge.
      if (m_axis_tvalid && m_axis_tready) begin
        checked++;
        if (payload_owed.size() == 0) begin
          fails++;
          if (fails <= MaxReports)
            $display("%0t: output word %02h (tlast %0b) with nothing expected",
                     $time, m_axis_tdata, m_axis_tlast);
        end else begin
          want = payload_owed.pop_front();
          if (m_axis_tdata !== want.data) begin
            fails++;
            if (fails <= MaxReports)
              $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                       $time, want.data, m_axis_tdata);
          end
          if (m_axis_tlast !== want.last) begin
            fails++;
            if (fails <= MaxReports)
              $display("%0t: last_out mismatch, expected %0b, actual %0b",
                       $time, want.last, m_axis_tlast);
          end
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        // Open a packet: reload every register and release the sync header.
        if (!pkt_open) begin
          crc_acc  = CrcStart;
          inner_st = InnerStart;
          outer_st = lead_in_state(seed_q);
          out_pos  = 0;
          pkt_open = 1'b1;
          owe_byte(outer_mask(mirror8(SyncByte0)), 1'b0);
          owe_byte(outer_mask(mirror8(SyncByte1)), 1'b0);
          owe_byte(outer_mask(mirror8(SyncByte2)), 1'b0);
        end
        // Address bytes go out mirrored; data bytes enter the CRC mirrored.
        crc_in  = s_axis_tuser ? s_axis_tdata : mirror8(s_axis_tdata);
        crc_acc = crc_acc ^ {crc_in, 8'h00};
        for (int i = 0; i < 8; i++)
          crc_acc = crc_acc[15] ? ({crc_acc[14:0], 1'b0} ^ CrcTaps) : {crc_acc[14:0], 1'b0};
        owe_byte(whiten(s_axis_tuser ? mirror8(s_axis_tdata) : s_axis_tdata), 1'b0);

        if (s_axis_tlast) begin
          crc_tail = ~mirror16(crc_acc);
          owe_byte(whiten(crc_tail[7:0]), 1'b0);
          // With no room for padding the CRC high byte closes the payload.
          owe_byte(whiten(crc_tail[15:8]), out_pos + 1 >= PAYLOAD_BYTES);
          while (out_pos < PAYLOAD_BYTES)
            owe_byte(8'(out_pos + 1), out_pos + 1 == PAYLOAD_BYTES);
          pkt_open = 1'b0;
        end
      end

      // A new seed only applies from the next packet opening.
      if (cfg_we_i) seed_q = cfg_wdata_i;
    end
    pending_o    <= payload_owed.size();
    fail_count_o <= fails;
    checked_o    <= checked;
  end

endmodule

// ----- dv/rf_payload_crc_whitening_builder_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rf_payload_crc_whitening_builder_test : top of the payload builder bench
// Drives address and data bytes into the builder, rewrites the whitening seed
// between packets and throttles both streams. The checker beside the block
// predicts and compares every payload byte. This module gives the verdict.
// ----------------------------------------------------------------------------
module rf_payload_crc_whitening_builder_test;

  localparam int unsigned PayloadBytes = 24;
  localparam int unsigned CycleLimit   = 400000;  // watchdog, many times the slowest run
  localparam int unsigned TailCycles   = 64;      // settle time after the last byte
  localparam int unsigned PhaseWords   = 60;      // random words per idling phase
  localparam int unsigned HugeLength   = 130;     // runs the position counter to its ceiling

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [5:0]  cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned word_count    = 0;
  int unsigned packet_count  = 0;
  int unsigned seed_writes   = 0;
  int unsigned cycle_count   = 0;
  logic        calm          = 1'b0;
  int unsigned calm_left     = 0;

  rf_payload_crc_whitening_builder #(
    .PAYLOAD_BYTES(PayloadBytes)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  rf_payload_crc_whitening_builder_checker #(
    .PAYLOAD_BYTES(PayloadBytes)
  ) payload_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin : clock_gen
    forever #1 clk_i = ~clk_i;
  end

  // Receiver: drop tready at the phase's rate, except in calm windows where
  // both sides run flat out for a while.
  always @(posedge clk_i) begin
    if (calm_left == 0) begin
      calm      <= ($urandom_range(3) == 0);
      calm_left <= 48;
    end else begin
      calm_left <= calm_left - 1;
    end
    m_axis_tready <= calm || ($urandom_range(99) >= recv_idle_pct);
  end

  // Offer one word and hold it until the handshake. tvalid stays high after
  // the word is taken, so back-to-back words need no extra edge.
  task automatic push_word(input logic [7:0] data, input logic is_addr, input logic fin);
    while (!calm && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= is_addr;
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    word_count++;
  endtask

  // Hold the sender off until every owed payload byte has left the block.
  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_seed(input logic [5:0] seed);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= seed;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    seed_writes++;
  endtask

  // Address bytes lead, data bytes follow; now and then flip a flag so an
  // address byte lands among data bytes, and now and then drain mid-packet.
  task automatic send_packet(input int unsigned len);
    int unsigned n_addr;
    logic        is_addr;
    n_addr = $urandom_range(0, (len < 5) ? len : 5);
    for (int unsigned i = 0; i < len; i++) begin
      is_addr = (i < n_addr);
      if ($urandom_range(9) == 0) is_addr = ~is_addr;
      if ($urandom_range(63) == 0) wait_quiet();
      push_word(8'($urandom_range(255)), is_addr, i == len - 1);
    end
    packet_count++;
  endtask

  initial begin : stimulus
    int unsigned phase_words;
    int unsigned len;
    int unsigned roll;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: one-byte packets at the reset seed, the extreme byte values.
    push_word(8'h00, 1'b0, 1'b1);
    push_word(8'hFF, 1'b1, 1'b1);
    packet_count += 2;

    // Mixed order at the top seed, with the sender held off mid-packet.
    wait_quiet();
    write_seed(6'd63);
    push_word(8'h00, 1'b1, 1'b0);
    push_word(8'hFF, 1'b0, 1'b0);
    wait_quiet();
    push_word(8'h80, 1'b1, 1'b0);
    push_word(8'h01, 1'b0, 1'b1);
    packet_count++;

    // Body just fills the payload: no padding, tlast on the CRC high byte.
    wait_quiet();
    write_seed(6'd0);
    for (int i = 0; i < 19; i++)
      push_word(8'(i * 37 + 5), 1'b0, i == 18);
    packet_count++;

    // Random packets over three idling phases.
    for (int phase = 0; phase < 3; phase++) begin
      wait_quiet();
      case (phase)
        0: begin
          send_idle_pct <= 28;
          recv_idle_pct <= 64;
          write_seed(6'd63);
        end
        1: begin
          send_idle_pct <= 64;
          recv_idle_pct <= 28;
          write_seed(6'd0);
        end
        default: begin
          send_idle_pct <= 0;
          recv_idle_pct <= 0;
          write_seed(6'($urandom_range(63)));
          // Past the position ceiling: the counter must hold, not wrap.
          send_packet(HugeLength);
        end
      endcase
      phase_words = 0;
      while (phase_words < PhaseWords) begin
        if (packet_count % 5 == 0) begin
          wait_quiet();
          write_seed(6'($urandom_range(63)));
        end
        roll = $urandom_range(99);
        if (roll < 50)      len = $urandom_range(1, 6);
        else if (roll < 85) len = $urandom_range(7, 18);
        else                len = $urandom_range(19, 30);
        send_packet(len);
        phase_words += len;
      end
    end

    wait_quiet();
    repeat (TailCycles) @(posedge clk_i);

    $display("Covered %0d packets from %0d input words, %0d payload bytes compared,",
             packet_count, word_count, checked);
    $display("over %0d seed writes and three idling mixes on both streams.", seed_writes);
    if (fail_count == 0 && pending == 0) begin
      $display("rf_payload_crc_whitening_builder verification clean");
    end else begin
      $display("rf_payload_crc_whitening_builder verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("rf_payload_crc_whitening_builder verification failed");
    $finish;
  end

endmodule
